// File: sv/rcsc_pkg.sv
// Package for the rotary carousel slot controller: widths, command and
// register codes, slot mask helpers. No dependencies.
package rcsc_pkg;

  // Drum geometry
  localparam int unsigned MAX_SLOTS = 8;
  localparam int unsigned SLOT_W    = 3;   // slot index
  localparam int unsigned CNT_W     = 4;   // slot count 3..8
  localparam int unsigned MAP_W     = 8;
  localparam int unsigned BYTE_W    = 8;

  // Motor step arithmetic
  localparam int unsigned SPR_W   = 15;
  localparam int unsigned STEPS_W = 14;
  localparam int unsigned NUM_W   = 18;    // 2*moves*spr + n fits in 18 bits
  localparam int unsigned REM_W   = 5;     // remainder < 2*n <= 16
  localparam int unsigned DIVC_W  = 5;     // iteration counter of the divider

  localparam logic [SPR_W-1:0] SPR_MIN   = 15'd200;
  localparam logic [SPR_W-1:0] SPR_MAX   = 15'd25600;
  localparam logic [SPR_W-1:0] SPR_RESET = 15'd1600;
  localparam logic [CNT_W-1:0] N_RESET   = 4'd5;

  // Config register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_CW_HIGH   = 8'd1;

  // Command codes
  localparam int unsigned CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_DISP_NEAREST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISP_SLOT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RET_NEAREST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_SLOT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_SPOKES   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STATUS       = 3'd5;

  // Bit i set for every slot below n
  function automatic logic [MAP_W-1:0] slot_mask(input logic [CNT_W-1:0] n);
    logic [MAP_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAP_W; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

  // Fresh map after a spoke change: slots 1 to n-1 filled
  function automatic logic [MAP_W-1:0] spoke_fill(input logic [CNT_W-1:0] n);
    return slot_mask(n) & ~MAP_W'(1);
  endfunction

  // Reduce a value below 2*n modulo n
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = (v >= n) ? (v - n) : v;
    return r[SLOT_W-1:0];
  endfunction

endpackage

// File: sv/rcsc_cmd_if.sv
// Command request channel of the carousel controller.
// Depends on rcsc_pkg for field widths.
interface rcsc_cmd_if;
  import rcsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] slot_sel;
  logic              fill_flag;
  logic [BYTE_W-1:0] new_spoke_count;
  logic              dock_ready;

  modport source (output valid, cmd, slot_sel, fill_flag, new_spoke_count, dock_ready,
                  input ready);
  modport sink   (input valid, cmd, slot_sel, fill_flag, new_spoke_count, dock_ready,
                  output ready);
endinterface

// File: sv/rcsc_rsp_if.sv
// Result channel of the carousel controller.
// Depends on rcsc_pkg for field widths.
interface rcsc_rsp_if;
  import rcsc_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [SLOT_W-1:0]  window_pos;
  logic [SLOT_W-1:0]  slot_moves;
  logic               move_cw;
  logic               dir_level;
  logic [STEPS_W-1:0] motor_steps;
  logic [MAP_W-1:0]   filled_map;
  logic [CNT_W-1:0]   spoke_count;
  logic [BYTE_W-1:0]  echo_slot;

  modport source (output valid, ok, window_pos, slot_moves, move_cw, dir_level,
                         motor_steps, filled_map, spoke_count, echo_slot,
                  input ready);
  modport sink   (input valid, ok, window_pos, slot_moves, move_cw, dir_level,
                        motor_steps, filled_map, spoke_count, echo_slot,
                  output ready);
endinterface

// File: sv/rcsc_cfg_if.sv
// Configuration write channel of the carousel controller.
// Depends on rcsc_pkg for index and data widths.
interface rcsc_cfg_if;
  import rcsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SPR_W-1:0]     wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: sv/rotary_carousel_slot_controller.sv
// Rotary carousel slot controller: slot map, window tracking, move planning
// and motor step calculation. Depends on rcsc_pkg and the three channel
// interfaces (rcsc_cmd_if, rcsc_rsp_if, rcsc_cfg_if).
//
// Usage:
//   req_i carries one command per request; rsp_o returns exactly one result
//   per command, in order. cfg_i writes steps_per_rev (index 0) and
//   dir_cw_high (index 1); it is always ready. The user must write it only
//   while idle; the block does not enforce this. One command is in flight at
//   a time; req_i.ready is high only when the sequencer is idle.
//   Sequencer states from accept to the result register, per command:
//     set slot, set spokes, status, commands refused on entry: output
//     dispense to slot: move, then output, via multiply and divide if the drum turns
//     dispense nearest: search walking cw to the first filled slot, then
//     move, multiply, a restoring divide by 2*n for the step rounding, output
//     return nearest: search slots 1 to n-1, then multiply, divide, output
//     (no move state); a search that finds nothing goes to output
//   The result sits in an output register; a stalled receiver holds it, and
//   the block finishes the next command up to that register before waiting.
//   Reset: window at 0, five slots with 1 to 4 filled, steps_per_rev 1600,
//   dir_cw_high 1, no result pending.
module rotary_carousel_slot_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcsc_cmd_if.sink   req_i,
  rcsc_rsp_if.source rsp_o,
  rcsc_cfg_if.sink   cfg_i
);
  import rcsc_pkg::*;

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_SEARCH = 3'd1;
  localparam logic [ST_W-1:0] S_MOVE   = 3'd2;
  localparam logic [ST_W-1:0] S_MUL    = 3'd3;
  localparam logic [ST_W-1:0] S_DIV    = 3'd4;
  localparam logic [ST_W-1:0] S_OUT    = 3'd5;
  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(NUM_W - 1);

  // Architectural state
  logic [ST_W-1:0]   state_q, state_d;
  logic [SLOT_W-1:0] win_q, win_d;
  logic [MAP_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [SPR_W-1:0]  spr_q;
  logic              dcwh_q;

  // Per-command working registers
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] tgt_q, tgt_d;
  logic [SLOT_W-1:0] best_q, best_d;
  logic              bcw_q, bcw_d;
  logic              found_q, found_d;
  logic              ok_q, ok_d;
  logic [SLOT_W-1:0] moves_q, moves_d;
  logic              cw_q, cw_d;
  logic [BYTE_W-1:0] echo_q, echo_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [REM_W-1:0]  rem_q, rem_d;

  // Result register
  logic               rv_q;
  logic               r_ok_q;
  logic [SLOT_W-1:0]  r_win_q, r_moves_q;
  logic               r_cw_q, r_dir_q;
  logic [STEPS_W-1:0] r_steps_q;
  logic [MAP_W-1:0]   r_map_q;
  logic [CNT_W-1:0]   r_n_q;
  logic [BYTE_W-1:0]  r_echo_q;

  logic accept, load_out;

  // Shared distance unit: cw and ccw pitch counts from window to one slot
  logic [SLOT_W-1:0] op_slot;
  logic [SLOT_W-1:0] dist_a, dist_b;
  logic [SLOT_W-1:0] near_d;
  logic              near_cw;
  logic              last_step;
  logic              ret_hit;

  assign op_slot = (state_q == S_MOVE) ? tgt_q : cnt_q[SLOT_W-1:0];
  assign dist_a  = wrap_slot({1'b0, win_q} + n_q - {1'b0, op_slot}, n_q);
  assign dist_b  = wrap_slot({1'b0, op_slot} + n_q - {1'b0, win_q}, n_q);
  assign near_cw = (dist_a < dist_b);
  assign near_d  = near_cw ? dist_a : dist_b;
  assign last_step = (cnt_q == (DIVC_W'(n_q) - DIVC_W'(1)));

  // Dispense search visits slot win-cnt, which is dist_a's slot walking cw
  logic [SLOT_W-1:0] walk_slot;
  assign walk_slot = dist_a;
  logic walk_hit;
  assign walk_hit = (walk_slot != '0) && fill_q[walk_slot];
  assign ret_hit  = !fill_q[op_slot] && (near_d != '0) && (!found_q || (near_d < best_q));

  // Restoring divider step
  logic [REM_W:0] trial, den;
  logic           q_bit;
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign den   = {1'b0, n_q, 1'b0};
  assign q_bit = (trial >= den);

  logic [NUM_W-1:0] prod;
  assign prod = NUM_W'(moves_q) * NUM_W'(spr_q);

  assign accept   = req_i.valid && req_i.ready;
  assign load_out = (state_q == S_OUT) && (!rv_q || rsp_o.ready);
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Sequencer
  always_comb begin
    state_d = state_q;
    win_d   = win_q;
    fill_d  = fill_q;
    n_d     = n_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    tgt_d   = tgt_q;
    best_d  = best_q;
    bcw_d   = bcw_q;
    found_d = found_q;
    ok_d    = ok_q;
    moves_d = moves_q;
    cw_d    = cw_q;
    echo_d  = echo_q;
    num_d   = num_q;
    rem_d   = rem_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = req_i.cmd;
          cnt_d   = DIVC_W'(1);
          found_d = 1'b0;
          best_d  = '0;
          bcw_d   = 1'b0;
          ok_d    = 1'b0;
          moves_d = '0;
          cw_d    = 1'b0;
          echo_d  = '0;
          num_d   = '0;
          state_d = S_OUT;
          unique case (req_i.cmd) inside
            CMD_DISP_NEAREST, CMD_RET_NEAREST: begin
              if (req_i.dock_ready) state_d = S_SEARCH;
            end
            CMD_DISP_SLOT: begin
              if (req_i.dock_ready && (req_i.slot_sel != '0) &&
                  (req_i.slot_sel < {4'b0, n_q}) &&
                  fill_q[req_i.slot_sel[SLOT_W-1:0]]) begin
                tgt_d   = req_i.slot_sel[SLOT_W-1:0];
                state_d = S_MOVE;
              end
            end
            CMD_SET_SLOT: begin
              echo_d = req_i.slot_sel;
              if (req_i.slot_sel < {4'b0, n_q}) begin
                fill_d[req_i.slot_sel[SLOT_W-1:0]] =
                  (req_i.slot_sel == '0) ? 1'b0 : req_i.fill_flag;
                ok_d = 1'b1;
              end
            end
            CMD_SET_SPOKES: begin
              if ((req_i.new_spoke_count >= 8'd3) &&
                  (req_i.new_spoke_count <= BYTE_W'(MAX_SLOTS))) begin
                n_d    = req_i.new_spoke_count[CNT_W-1:0];
                fill_d = spoke_fill(req_i.new_spoke_count[CNT_W-1:0]);
                win_d  = '0;
                ok_d   = 1'b1;
              end
            end
            CMD_STATUS: ok_d = 1'b1;
            default: ok_d = 1'b0;
          endcase
        end
      end
      S_SEARCH: begin
        if (cmd_q == CMD_DISP_NEAREST) begin
          // Walk clockwise from the window, first filled slot wins
          if (walk_hit) begin
            tgt_d   = walk_slot;
            state_d = S_MOVE;
          end else if (last_step) begin
            state_d = S_OUT;
          end else begin
            cnt_d = cnt_q + DIVC_W'(1);
          end
        end else begin
          // Return nearest: keep the strictly closest empty slot
          if (ret_hit) begin
            best_d  = near_d;
            bcw_d   = near_cw;
            tgt_d   = op_slot;
            found_d = 1'b1;
          end
          if (last_step) begin
            if (ret_hit || found_q) begin
              ok_d    = 1'b1;
              moves_d = best_d;
              cw_d    = bcw_d;
              win_d   = tgt_d;
              fill_d[tgt_d] = 1'b1;
              state_d = S_MUL;
            end else begin
              state_d = S_OUT;
            end
          end else begin
            cnt_d = cnt_q + DIVC_W'(1);
          end
        end
      end
      S_MOVE: begin
        // Shorter way round, tie goes clockwise
        ok_d  = 1'b1;
        win_d = tgt_q;
        fill_d[tgt_q] = 1'b0;
        if (dist_a <= dist_b) begin
          moves_d = dist_a;
          cw_d    = (dist_a != '0);
        end else begin
          moves_d = dist_b;
          cw_d    = 1'b0;
        end
        state_d = ((dist_a == '0) || (dist_b == '0)) ? S_OUT : S_MUL;
      end
      S_MUL: begin
        num_d   = {prod[NUM_W-2:0], 1'b0} + NUM_W'(n_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = q_bit ? REM_W'(trial - den) : REM_W'(trial);
        num_d = {num_q[NUM_W-2:0], q_bit};
        if (cnt_q == DIV_LAST) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + DIVC_W'(1);
        end
      end
      S_OUT: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      win_q   <= '0;
      fill_q  <= spoke_fill(N_RESET);
      n_q     <= N_RESET;
      spr_q   <= SPR_RESET;
      dcwh_q  <= 1'b1;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      n_q     <= n_d;
      if (cfg_i.valid) begin
        if ((cfg_i.index == REG_STEPS_PER_REV) &&
            (cfg_i.wdata >= SPR_MIN) && (cfg_i.wdata <= SPR_MAX)) begin
          spr_q <= cfg_i.wdata;
        end else if (cfg_i.index == REG_DIR_CW_HIGH) begin
          dcwh_q <= cfg_i.wdata[0];
        end
      end
      if (load_out) begin
        rv_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rv_q <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cnt_q   <= cnt_d;
    tgt_q   <= tgt_d;
    best_q  <= best_d;
    bcw_q   <= bcw_d;
    found_q <= found_d;
    ok_q    <= ok_d;
    moves_q <= moves_d;
    cw_q    <= cw_d;
    echo_q  <= echo_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    if (load_out) begin
      r_ok_q    <= ok_q;
      r_win_q   <= win_q;
      r_moves_q <= moves_q;
      r_cw_q    <= cw_q;
      r_dir_q   <= (moves_q != '0) && (cw_q == dcwh_q);
      r_steps_q <= num_q[STEPS_W-1:0];
      r_map_q   <= fill_q & slot_mask(n_q);
      r_n_q     <= n_q;
      r_echo_q  <= echo_q;
    end
  end

  assign rsp_o.valid       = rv_q;
  assign rsp_o.ok          = r_ok_q;
  assign rsp_o.window_pos  = r_win_q;
  assign rsp_o.slot_moves  = r_moves_q;
  assign rsp_o.move_cw     = r_cw_q;
  assign rsp_o.dir_level   = r_dir_q;
  assign rsp_o.motor_steps = r_steps_q;
  assign rsp_o.filled_map  = r_map_q;
  assign rsp_o.spoke_count = r_n_q;
  assign rsp_o.echo_slot   = r_echo_q;

endmodule
